// ===== hdl/srsh_pkg.sv =====
// Shared types, constants and the multiply-accumulate micro-program of the sphere hit block.
`timescale 1ns / 1ps
package srsh_pkg;

  localparam int MAX_RECEIVERS_DEF = 16;
  localparam int COORD_BITS_DEF    = 32;
  localparam int COUNT_W           = 5;
  localparam int RADIUS_W          = 31;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 31;
  localparam int ENTRY_W           = 4;
  localparam int HIT_IDX_W         = 4;
  localparam int PC_W              = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECEIVER_COUNT = 1'b0,
    REG_SPHERE_RADIUS  = 1'b1
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Operand sources of the shared multiplier
  typedef enum logic [3:0] {
    SRC_AB0, SRC_AB1, SRC_AB2,
    SRC_AP0, SRC_AP1, SRC_AP2,
    SRC_EP0, SRC_EP1, SRC_EP2,
    SRC_C0, SRC_C1, SRC_C2,
    SRC_RAD, SRC_R2, SRC_ABSQ
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_ABSQ, DST_R2, DST_R2ABSQ, DST_DOT, DST_C0, DST_C1, DST_C2
  } dst_t;

  typedef struct packed {
    src_t a_sel;
    src_t b_sel;
    logic sub;
    logic clr;
    logic wide;
    dst_t dst;
    logic last;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_FETCH, ST_DIFF, ST_BRANCH, ST_TEST, ST_EMIT_MID, ST_EMIT_END
  } state_t;

  typedef struct packed {
    logic                 wr_entry;
    logic                 capture;
    logic                 rd;
    logic                 diff;
    logic                 mac;
    uop_t                 uop;
    logic [1:0]           digit;
    logic                 store;
    logic                 thr_wide;
    logic                 out_load;
    logic [HIT_IDX_W-1:0] out_idx;
    logic                 out_hit;
    logic                 out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic dot_le0;
    logic absq_le_dot;
    logic near;
    logic zero_len;
    logic out_free;
  } dp_stat_t;

  // Program entry and exit points
  localparam logic [PC_W-1:0] PC_PREP      = 5'd0;
  localparam logic [PC_W-1:0] PC_PREP_END  = 5'd4;
  localparam logic [PC_W-1:0] PC_DOT       = 5'd5;
  localparam logic [PC_W-1:0] PC_DOT_END   = 5'd7;
  localparam logic [PC_W-1:0] PC_NEAR      = 5'd8;
  localparam logic [PC_W-1:0] PC_FAR       = 5'd11;
  localparam logic [PC_W-1:0] PC_CROSS     = 5'd14;
  localparam logic [PC_W-1:0] PC_CROSS_END = 5'd22;

  function automatic uop_t mk(input src_t a, input src_t b, input logic sub, input logic clr,
                              input logic wide, input dst_t dst, input logic last);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sub   = sub;
    u.clr   = clr;
    u.wide  = wide;
    u.dst   = dst;
    u.last  = last;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // query setup: |ab|^2, R^2, R^2*|ab|^2
      5'd0:  u = mk(SRC_AB0, SRC_AB0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd1:  u = mk(SRC_AB1, SRC_AB1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
      5'd2:  u = mk(SRC_AB2, SRC_AB2, 1'b0, 1'b0, 1'b0, DST_ABSQ, 1'b0);
      5'd3:  u = mk(SRC_RAD, SRC_RAD, 1'b0, 1'b1, 1'b1, DST_R2, 1'b0);
      5'd4:  u = mk(SRC_R2, SRC_ABSQ, 1'b0, 1'b1, 1'b1, DST_R2ABSQ, 1'b1);
      // ap . ab
      5'd5:  u = mk(SRC_AP0, SRC_AB0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd6:  u = mk(SRC_AP1, SRC_AB1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
      5'd7:  u = mk(SRC_AP2, SRC_AB2, 1'b0, 1'b0, 1'b0, DST_DOT, 1'b1);
      // distance to start
      5'd8:  u = mk(SRC_AP0, SRC_AP0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd9:  u = mk(SRC_AP1, SRC_AP1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
      5'd10: u = mk(SRC_AP2, SRC_AP2, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b1);
      // distance to end
      5'd11: u = mk(SRC_EP0, SRC_EP0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd12: u = mk(SRC_EP1, SRC_EP1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
      5'd13: u = mk(SRC_EP2, SRC_EP2, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b1);
      // cross product ap x ab and its squared length
      5'd14: u = mk(SRC_AP1, SRC_AB2, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd15: u = mk(SRC_AP2, SRC_AB1, 1'b1, 1'b0, 1'b0, DST_C0, 1'b0);
      5'd16: u = mk(SRC_AP2, SRC_AB0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd17: u = mk(SRC_AP0, SRC_AB2, 1'b1, 1'b0, 1'b0, DST_C1, 1'b0);
      5'd18: u = mk(SRC_AP0, SRC_AB1, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
      5'd19: u = mk(SRC_AP1, SRC_AB0, 1'b1, 1'b0, 1'b0, DST_C2, 1'b0);
      5'd20: u = mk(SRC_C0, SRC_C0, 1'b0, 1'b1, 1'b1, DST_NONE, 1'b0);
      5'd21: u = mk(SRC_C1, SRC_C1, 1'b0, 1'b0, 1'b1, DST_NONE, 1'b0);
      5'd22: u = mk(SRC_C2, SRC_C2, 1'b0, 1'b0, 1'b1, DST_NONE, 1'b1);
      default: u = mk(SRC_AB0, SRC_AB0, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/srsh_if.sv =====
// Valid/ready channel interfaces for query/write transactions and hit results.
`timescale 1ns / 1ps
interface srsh_in_if #(parameter int COORD_BITS = srsh_pkg::COORD_BITS_DEF);
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic        [srsh_pkg::ENTRY_W-1:0]  entry_index;
  logic signed [COORD_BITS-1:0]         receiver_x;
  logic signed [COORD_BITS-1:0]         receiver_y;
  logic signed [COORD_BITS-1:0]         receiver_z;
  logic signed [COORD_BITS-1:0]         start_x;
  logic signed [COORD_BITS-1:0]         start_y;
  logic signed [COORD_BITS-1:0]         start_z;
  logic signed [COORD_BITS-1:0]         end_x;
  logic signed [COORD_BITS-1:0]         end_y;
  logic signed [COORD_BITS-1:0]         end_z;

  modport source (output valid, operation, entry_index, receiver_x, receiver_y, receiver_z,
                  start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, operation, entry_index, receiver_x, receiver_y, receiver_z,
                start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface srsh_out_if;
  logic                             valid;
  logic                             ready;
  logic [srsh_pkg::HIT_IDX_W-1:0]   hit_index;
  logic                             hit;
  logic                             last;

  modport source (output valid, hit_index, hit, last, input ready);
  modport sink (input valid, hit_index, hit, last, output ready);
endinterface

// ===== hdl/srsh_datapath.sv =====
// Datapath: receiver table, shared digit-serial multiply-accumulate unit, result register.
`timescale 1ns / 1ps
module srsh_datapath #(
  parameter int MAX_RECEIVERS = srsh_pkg::MAX_RECEIVERS_DEF,
  parameter int COORD_BITS    = srsh_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [srsh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srsh_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [srsh_pkg::ENTRY_W-1:0]          entry_index,
  input  logic signed [COORD_BITS-1:0]          receiver_x,
  input  logic signed [COORD_BITS-1:0]          receiver_y,
  input  logic signed [COORD_BITS-1:0]          receiver_z,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          start_z,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic signed [COORD_BITS-1:0]          end_z,
  input  logic [((MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1)-1:0] rd_idx,
  input  srsh_pkg::dp_cmd_t                     cmd,
  output srsh_pkg::dp_stat_t                    stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [srsh_pkg::HIT_IDX_W-1:0]        out_hit_index,
  output logic                                  out_hit,
  output logic                                  out_last
);

  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int AW    = (2 * DW + 2 > 2 * srsh_pkg::RADIUS_W + 1) ?
                         2 * DW + 2 : 2 * srsh_pkg::RADIUS_W + 1;
  localparam int DIGW  = (2 * DW + 3) / 4;
  localparam int BMW   = (AW > 4 * DIGW) ? AW : 4 * DIGW;
  localparam int AEW   = AW + 1;
  localparam int PW    = AEW + DIGW + 1;
  localparam int ACCW  = AEW + 4 * DIGW + 2;

  logic signed [COORD_BITS-1:0] mem_x [MAX_RECEIVERS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_RECEIVERS];
  logic signed [COORD_BITS-1:0] mem_z [MAX_RECEIVERS];

  logic signed [COORD_BITS-1:0] rx_r, ry_r, rz_r;
  logic signed [COORD_BITS-1:0] s_r [3];
  logic signed [COORD_BITS-1:0] e_r [3];
  logic signed [DW-1:0]         ab_r [3];
  logic signed [DW-1:0]         ap_r [3];
  logic signed [DW-1:0]         ep_r [3];
  logic signed [AW-1:0]         c_r [3];
  logic [srsh_pkg::RADIUS_W-1:0] radius_r;
  logic signed [ACCW-1:0]       acc_r, acc_nxt;
  logic signed [ACCW-1:0]       absq_r, r2_r, r2absq_r, dot_r;
  logic                         out_valid_r;
  logic [srsh_pkg::HIT_IDX_W-1:0] out_idx_r;
  logic                         out_hit_r, out_last_r;

  logic signed [AW-1:0]   a_val, b_val;
  logic [AW-1:0]          b_mag;
  logic [BMW-1:0]         b_ext;
  logic [DIGW-1:0]        digit;
  logic                   neg;
  logic signed [AEW-1:0]  a_ext, a_eff;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] term_w, acc_base;
  logic [IDX_W-1:0]       widx;

  function automatic logic signed [AW-1:0] src_val(input srsh_pkg::src_t sel);
    logic signed [AW-1:0] v;
    case (sel)
      srsh_pkg::SRC_AB0:  v = AW'(ab_r[0]);
      srsh_pkg::SRC_AB1:  v = AW'(ab_r[1]);
      srsh_pkg::SRC_AB2:  v = AW'(ab_r[2]);
      srsh_pkg::SRC_AP0:  v = AW'(ap_r[0]);
      srsh_pkg::SRC_AP1:  v = AW'(ap_r[1]);
      srsh_pkg::SRC_AP2:  v = AW'(ap_r[2]);
      srsh_pkg::SRC_EP0:  v = AW'(ep_r[0]);
      srsh_pkg::SRC_EP1:  v = AW'(ep_r[1]);
      srsh_pkg::SRC_EP2:  v = AW'(ep_r[2]);
      srsh_pkg::SRC_C0:   v = c_r[0];
      srsh_pkg::SRC_C1:   v = c_r[1];
      srsh_pkg::SRC_C2:   v = c_r[2];
      srsh_pkg::SRC_RAD:  v = AW'($signed({1'b0, radius_r}));
      srsh_pkg::SRC_R2:   v = r2_r[AW-1:0];
      srsh_pkg::SRC_ABSQ: v = absq_r[AW-1:0];
      default:            v = '0;
    endcase
    return v;
  endfunction

  // One digit of b per cycle; sign of b folded into a
  always_comb begin
    a_val    = src_val(cmd.uop.a_sel);
    b_val    = src_val(cmd.uop.b_sel);
    b_mag    = b_val[AW-1] ? AW'(-b_val) : AW'(b_val);
    b_ext    = BMW'(b_mag);
    digit    = b_ext[cmd.digit * DIGW +: DIGW];
    neg      = b_val[AW-1] ^ cmd.uop.sub;
    a_ext    = AEW'(a_val);
    a_eff    = neg ? -a_ext : a_ext;
    prod     = a_eff * $signed({1'b0, digit});
    term_w   = ACCW'(prod) <<< (cmd.digit * DIGW);
    acc_base = (cmd.uop.clr && cmd.digit == 2'd0) ? '0 : acc_r;
    acc_nxt  = acc_base + term_w;
  end

  assign widx = IDX_W'(entry_index);

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && (int'(entry_index) < MAX_RECEIVERS)) begin
      mem_x[widx] <= receiver_x;
      mem_y[widx] <= receiver_y;
      mem_z[widx] <= receiver_z;
    end
    if (cmd.rd) begin
      rx_r <= mem_x[rd_idx];
      ry_r <= mem_y[rd_idx];
      rz_r <= mem_z[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_r[0]  <= start_x;
      s_r[1]  <= start_y;
      s_r[2]  <= start_z;
      e_r[0]  <= end_x;
      e_r[1]  <= end_y;
      e_r[2]  <= end_z;
      ab_r[0] <= DW'(end_x) - DW'(start_x);
      ab_r[1] <= DW'(end_y) - DW'(start_y);
      ab_r[2] <= DW'(end_z) - DW'(start_z);
    end
    if (cmd.diff) begin
      ap_r[0] <= DW'(rx_r) - DW'(s_r[0]);
      ap_r[1] <= DW'(ry_r) - DW'(s_r[1]);
      ap_r[2] <= DW'(rz_r) - DW'(s_r[2]);
      ep_r[0] <= DW'(rx_r) - DW'(e_r[0]);
      ep_r[1] <= DW'(ry_r) - DW'(e_r[1]);
      ep_r[2] <= DW'(rz_r) - DW'(e_r[2]);
    end
    if (cmd.mac) begin
      acc_r <= acc_nxt;
    end
    if (cmd.store) begin
      case (cmd.uop.dst)
        srsh_pkg::DST_ABSQ:   absq_r   <= acc_nxt;
        srsh_pkg::DST_R2:     r2_r     <= acc_nxt;
        srsh_pkg::DST_R2ABSQ: r2absq_r <= acc_nxt;
        srsh_pkg::DST_DOT:    dot_r    <= acc_nxt;
        srsh_pkg::DST_C0:     c_r[0]   <= acc_nxt[AW-1:0];
        srsh_pkg::DST_C1:     c_r[1]   <= acc_nxt[AW-1:0];
        srsh_pkg::DST_C2:     c_r[2]   <= acc_nxt[AW-1:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_idx_r  <= cmd.out_idx;
      out_hit_r  <= cmd.out_hit;
      out_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == srsh_pkg::REG_SPHERE_RADIUS) begin
        radius_r <= cfg_wdata[srsh_pkg::RADIUS_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.dot_le0     = (dot_r <= 0);
    stat.absq_le_dot = (absq_r <= dot_r);
    stat.near        = cmd.thr_wide ? (acc_r <= r2absq_r) : (acc_r <= r2_r);
    stat.zero_len    = (absq_r == '0);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_hit_index = out_idx_r;
  assign out_hit       = out_hit_r;
  assign out_last      = out_last_r;

endmodule

// ===== hdl/srsh_ctrl.sv =====
// Controller: sequences the micro-program per receiver and orders the result transactions.
`timescale 1ns / 1ps
module srsh_ctrl #(
  parameter int MAX_RECEIVERS = srsh_pkg::MAX_RECEIVERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [srsh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srsh_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_operation,
  output logic                                  in_ready,
  output logic [((MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1)-1:0] rd_idx,
  output srsh_pkg::dp_cmd_t                     cmd,
  input  srsh_pkg::dp_stat_t                    stat
);

  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
  localparam int CNT_W = (IDX_W + 1 > srsh_pkg::COUNT_W) ? IDX_W + 1 : srsh_pkg::COUNT_W;

  srsh_pkg::state_t                 state_r, state_nxt;
  logic [srsh_pkg::PC_W-1:0]        pc_r, pc_nxt;
  logic [1:0]                       dig_r, dig_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic [IDX_W-1:0]                 pend_r, pend_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [srsh_pkg::COUNT_W-1:0]     count_r;
  logic [CNT_W-1:0]                 lim;
  logic                             accept, lastdig, at_end;
  srsh_pkg::uop_t                   uop;

  assign uop     = srsh_pkg::uop_rom(pc_r);
  assign accept  = in_valid && (state_r == srsh_pkg::ST_IDLE);
  assign lastdig = (dig_r == (uop.wide ? 2'd3 : 2'd1));
  assign lim     = (CNT_W'(count_r) > CNT_W'(MAX_RECEIVERS)) ?
                   CNT_W'(MAX_RECEIVERS) : CNT_W'(count_r);
  assign at_end  = (idx_r + CNT_W'(1) == lim);
  assign rd_idx  = idx_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= srsh_pkg::ST_IDLE;
      pc_r     <= '0;
      dig_r    <= '0;
      idx_r    <= '0;
      pend_r   <= '0;
      pend_v_r <= 1'b0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      dig_r    <= dig_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_we && cfg_index == srsh_pkg::REG_RECEIVER_COUNT) begin
        count_r <= cfg_wdata[srsh_pkg::COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    dig_nxt    = dig_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    case (state_r)
      srsh_pkg::ST_IDLE: begin
        if (accept && in_operation == srsh_pkg::OP_QUERY) begin
          state_nxt  = srsh_pkg::ST_MAC;
          pc_nxt     = srsh_pkg::PC_PREP;
          dig_nxt    = '0;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
        end
      end
      srsh_pkg::ST_MAC: begin
        dig_nxt = dig_r + 2'd1;
        if (lastdig) begin
          dig_nxt = '0;
          if (uop.last) begin
            if (pc_r == srsh_pkg::PC_PREP_END) begin
              state_nxt = (lim == '0) ? srsh_pkg::ST_EMIT_END : srsh_pkg::ST_FETCH;
            end else if (pc_r == srsh_pkg::PC_DOT_END) begin
              state_nxt = srsh_pkg::ST_BRANCH;
            end else begin
              state_nxt = srsh_pkg::ST_TEST;
            end
          end else begin
            pc_nxt = pc_r + srsh_pkg::PC_W'(1);
          end
        end
      end
      srsh_pkg::ST_FETCH: state_nxt = srsh_pkg::ST_DIFF;
      srsh_pkg::ST_DIFF: begin
        state_nxt = srsh_pkg::ST_MAC;
        pc_nxt    = srsh_pkg::PC_DOT;
      end
      srsh_pkg::ST_BRANCH: begin
        state_nxt = srsh_pkg::ST_MAC;
        if (stat.dot_le0) begin
          pc_nxt = srsh_pkg::PC_NEAR;
        end else if (stat.absq_le_dot) begin
          pc_nxt = srsh_pkg::PC_FAR;
        end else begin
          pc_nxt = srsh_pkg::PC_CROSS;
        end
      end
      srsh_pkg::ST_TEST: begin
        if (stat.near && pend_v_r) begin
          // earlier hit goes out first, this one is held
          state_nxt = srsh_pkg::ST_EMIT_MID;
        end else begin
          if (stat.near) begin
            pend_nxt   = idx_r[IDX_W-1:0];
            pend_v_nxt = 1'b1;
          end
          if ((stat.near && !stat.zero_len) || at_end) begin
            state_nxt = srsh_pkg::ST_EMIT_END;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = srsh_pkg::ST_FETCH;
          end
        end
      end
      srsh_pkg::ST_EMIT_MID: begin
        if (stat.out_free) begin
          pend_nxt = idx_r[IDX_W-1:0];
          if (at_end) begin
            state_nxt = srsh_pkg::ST_EMIT_END;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = srsh_pkg::ST_FETCH;
          end
        end
      end
      srsh_pkg::ST_EMIT_END: begin
        if (stat.out_free) begin
          state_nxt = srsh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srsh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == srsh_pkg::ST_IDLE);
    cmd.wr_entry = accept && in_operation == srsh_pkg::OP_WRITE;
    cmd.capture  = accept && in_operation == srsh_pkg::OP_QUERY;
    cmd.rd       = (state_r == srsh_pkg::ST_FETCH);
    cmd.diff     = (state_r == srsh_pkg::ST_DIFF);
    cmd.mac      = (state_r == srsh_pkg::ST_MAC);
    cmd.uop      = uop;
    cmd.digit    = dig_r;
    cmd.store    = (state_r == srsh_pkg::ST_MAC) && lastdig;
    cmd.thr_wide = (pc_r == srsh_pkg::PC_CROSS_END);
    cmd.out_load = stat.out_free && ((state_r == srsh_pkg::ST_EMIT_MID) ||
                                     (state_r == srsh_pkg::ST_EMIT_END));
    cmd.out_last = (state_r == srsh_pkg::ST_EMIT_END);
    cmd.out_hit  = (state_r == srsh_pkg::ST_EMIT_MID) || pend_v_r;
    cmd.out_idx  = cmd.out_hit ? srsh_pkg::HIT_IDX_W'(pend_r) : '0;
  end

endmodule

// ===== hdl/segment_receiver_sphere_hits_core.sv =====
// Top level: segment-versus-receiver-sphere hit test with a loadable receiver table.
`timescale 1ns / 1ps
// Write transactions (operation 0) store one receiver position and give no result. A
// query transaction (operation 1) first runs the setup (|ab|^2, R^2 and R^2*|ab|^2),
// then tests each receiver in turn, by the distance to a segment end where its
// nearest point lies there or by the cross-product form where it does not, and hands
// out its results. All of it runs through one shared multiply-accumulate unit that takes
// a 17-bit digit of its second operand per cycle into an exact wide accumulator; that
// unit sets the rate. A new transaction is taken once the last result of a query is in
// the output register, while it still waits. A zero-length segment reports every
// receiver within the radius of its start; any other segment reports the first one
// only; no hit gives a single result with hit low.
module segment_receiver_sphere_hits_core #(
  parameter int MAX_RECEIVERS = srsh_pkg::MAX_RECEIVERS_DEF,
  parameter int COORD_BITS    = srsh_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  srsh_in_if.sink                            in_chan,
  srsh_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [srsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srsh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;

  srsh_pkg::dp_cmd_t  cmd;
  srsh_pkg::dp_stat_t stat;
  logic [IDX_W-1:0]   rd_idx;

  srsh_ctrl #(
    .MAX_RECEIVERS (MAX_RECEIVERS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .rd_idx       (rd_idx),
    .cmd          (cmd),
    .stat         (stat)
  );

  srsh_datapath #(
    .MAX_RECEIVERS (MAX_RECEIVERS),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .entry_index   (in_chan.entry_index),
    .receiver_x    (in_chan.receiver_x),
    .receiver_y    (in_chan.receiver_y),
    .receiver_z    (in_chan.receiver_z),
    .start_x       (in_chan.start_x),
    .start_y       (in_chan.start_y),
    .start_z       (in_chan.start_z),
    .end_x         (in_chan.end_x),
    .end_y         (in_chan.end_y),
    .end_z         (in_chan.end_z),
    .rd_idx        (rd_idx),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_hit_index (out_chan.hit_index),
    .out_hit       (out_chan.hit),
    .out_last      (out_chan.last)
  );

endmodule

// ===== hdl/srsh_checker.sv =====
// Port-level assertions for the sphere hit block, bound to the top level.
`timescale 1ns / 1ps
module srsh_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_operation,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [srsh_pkg::HIT_IDX_W-1:0]   out_hit_index,
  input logic                             out_hit,
  input logic                             out_last
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_index) && $stable(out_hit)
      && $stable(out_last))
    else $error("result changed while stalled");

  // a query leaves the input not ready once it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == srsh_pkg::OP_QUERY |=> !in_ready)
    else $error("new transaction taken right after a query");

  // a table write never blocks the next transaction
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == srsh_pkg::OP_WRITE |=> in_ready)
    else $error("table write stalled the input");

  // a no-hit result is the sole, final one of its query
  a_nohit_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last && out_hit_index == '0)
    else $error("malformed no-hit result");

endmodule

bind segment_receiver_sphere_hits_core srsh_checker u_srsh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_operation  (in_chan.operation),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_hit_index (out_chan.hit_index),
  .out_hit       (out_chan.hit),
  .out_last      (out_chan.last)
);

// ===== tb/sv/segment_receiver_sphere_hits_core_tb.sv =====
// Self-checking testbench for the segment versus receiver-sphere hit block.
`timescale 1ns / 1ps
module segment_receiver_sphere_hits_core_tb;

  typedef logic signed [255:0] acc_t;
  typedef logic signed [31:0] coord_t;

  typedef struct {
    logic                         op;
    logic [srsh_pkg::ENTRY_W-1:0] idx;
    coord_t                       rx, ry, rz;
    coord_t                       sx, sy, sz;
    coord_t                       ex, ey, ez;
  } txn_t;

  typedef struct {
    logic [srsh_pkg::HIT_IDX_W-1:0] hit_index;
    logic                           hit;
    logic                           last;
  } hit_rec_t;

  typedef enum int {ROW_TXN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    txn_t               t;
    bit                 typed;
    hit_rec_t           want;
    srsh_pkg::cfg_reg_t reg_idx;
    logic [30:0]        value;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [srsh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [srsh_pkg::CFG_DATA_W-1:0] cfg_wdata;

  srsh_in_if  in_chan();
  srsh_out_if out_chan();

  segment_receiver_sphere_hits_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  coord_t tab_x [16];
  coord_t tab_y [16];
  coord_t tab_z [16];
  logic [4:0]  rcv_count;
  logic [30:0] radius;

  hit_rec_t pending_hits[$];
  int errors = 0;
  int n_queries = 0;
  int n_results = 0;
  int n_hits = 0;
  int burst_left = 0;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("segment_receiver_sphere_hits_core verification failed");
    $finish;
  end

  function automatic acc_t dot3(acc_t a0, acc_t a1, acc_t a2, acc_t b0, acc_t b1, acc_t b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  function automatic bit within_radius(txn_t t, int i);
    acc_t s[3], e[3], ab[3], ap[3], ep[3];
    acc_t ab2, r2, dot, c0, c1, c2;
    s[0] = t.sx; s[1] = t.sy; s[2] = t.sz;
    e[0] = t.ex; e[1] = t.ey; e[2] = t.ez;
    r2 = acc_t'(radius) * acc_t'(radius);
    for (int k = 0; k < 3; k++) ab[k] = e[k] - s[k];
    ap[0] = acc_t'(tab_x[i]) - s[0];
    ap[1] = acc_t'(tab_y[i]) - s[1];
    ap[2] = acc_t'(tab_z[i]) - s[2];
    ep[0] = acc_t'(tab_x[i]) - e[0];
    ep[1] = acc_t'(tab_y[i]) - e[1];
    ep[2] = acc_t'(tab_z[i]) - e[2];
    ab2 = dot3(ab[0], ab[1], ab[2], ab[0], ab[1], ab[2]);
    dot = dot3(ap[0], ap[1], ap[2], ab[0], ab[1], ab[2]);
    if (ab2 == 0 || dot <= 0)
      return dot3(ap[0], ap[1], ap[2], ap[0], ap[1], ap[2]) <= r2;
    if (ab2 <= dot)
      return dot3(ep[0], ep[1], ep[2], ep[0], ep[1], ep[2]) <= r2;
    c0 = ap[1] * ab[2] - ap[2] * ab[1];
    c1 = ap[2] * ab[0] - ap[0] * ab[2];
    c2 = ap[0] * ab[1] - ap[1] * ab[0];
    return c0 * c0 + c1 * c1 + c2 * c2 <= r2 * ab2;
  endfunction

  // updates the table on writes, queues the hit list for queries
  function automatic void predict_hits(txn_t t);
    int n;
    bit zero_len;
    int found;
    hit_rec_t r;
    if (t.op == srsh_pkg::OP_WRITE) begin
      tab_x[t.idx] = t.rx;
      tab_y[t.idx] = t.ry;
      tab_z[t.idx] = t.rz;
      return;
    end
    n = (rcv_count > 16) ? 16 : rcv_count;
    zero_len = (t.sx == t.ex) && (t.sy == t.ey) && (t.sz == t.ez);
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (within_radius(t, i)) begin
        if (found > 0) pending_hits[$].last = 1'b0;
        r.hit_index = i[srsh_pkg::HIT_IDX_W-1:0];
        r.hit = 1'b1;
        r.last = 1'b1;
        pending_hits = {pending_hits, r};
        found++;
        if (!zero_len) break;
      end
    end
    if (found == 0) begin
      r = '{hit_index: '0, hit: 1'b0, last: 1'b1};
      pending_hits = {pending_hits, r};
    end
  endfunction

  task automatic write_reg(srsh_pkg::cfg_reg_t idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srsh_pkg::REG_RECEIVER_COUNT) rcv_count = value[4:0];
    else radius = value;
  endtask

  // a write transaction may still be in flight after the queue drains
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_txn(txn_t t, bit typed, hit_rec_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.operation <= t.op;
    in_chan.entry_index <= t.idx;
    in_chan.receiver_x <= t.rx;
    in_chan.receiver_y <= t.ry;
    in_chan.receiver_z <= t.rz;
    in_chan.start_x <= t.sx;
    in_chan.start_y <= t.sy;
    in_chan.start_z <= t.sz;
    in_chan.end_x <= t.ex;
    in_chan.end_y <= t.ey;
    in_chan.end_z <= t.ez;
    do @(posedge clk); while (!in_chan.ready);
    if (t.op == srsh_pkg::OP_QUERY) n_queries++;
    if (typed) begin
      if (t.op == srsh_pkg::OP_WRITE) predict_hits(t);
      else pending_hits = {pending_hits, want};
    end else begin
      predict_hits(t);
    end
  endtask

  // result side: the stall pattern moves through always ready, a fixed pattern and random stalls
  int cyc = 0;
  always @(posedge clk) begin
    hit_rec_t w;
    cyc <= cyc + 1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_results++;
      if (out_chan.hit) n_hits++;
      if (pending_hits.size() == 0) begin
        $error("unexpected result transaction: hit_index %0d hit %0d last %0d",
               out_chan.hit_index, out_chan.hit, out_chan.last);
        errors++;
      end else begin
        w = pending_hits.pop_front();
        if (out_chan.hit_index !== w.hit_index) begin
          $error("hit_index: expected %0d, got %0d", w.hit_index, out_chan.hit_index);
          errors++;
        end
        if (out_chan.hit !== w.hit) begin
          $error("hit: expected %0d, got %0d", w.hit, out_chan.hit);
          errors++;
        end
        if (out_chan.last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, out_chan.last);
          errors++;
        end
      end
    end
    case ((cyc / 600) % 3)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= (cyc % 5) != 2;
      default: out_chan.ready <= $urandom_range(0, 2) != 0;
    endcase
  end

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  function automatic txn_t rand_txn();
    txn_t t;
    t.op = ($urandom_range(0, 9) < 3) ? srsh_pkg::OP_WRITE : srsh_pkg::OP_QUERY;
    t.idx = $urandom_range(0, 15);
    t.rx = rand_coord(); t.ry = rand_coord(); t.rz = rand_coord();
    t.sx = rand_coord(); t.sy = rand_coord(); t.sz = rand_coord();
    case ($urandom_range(0, 4))
      0: begin t.ex = t.sx; t.ey = t.sy; t.ez = t.sz; end
      1: begin t.ex = rand_coord(); t.ey = rand_coord(); t.ez = rand_coord(); end
      default: begin
        t.ex = t.sx + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
        t.ey = t.sy + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
        t.ez = t.sz + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
      end
    endcase
    return t;
  endfunction

  function automatic row_t blank_row(row_kind_t kind);
    row_t r;
    r.kind = kind;
    r.t = '{op: srsh_pkg::OP_WRITE, idx: '0, default: '0};
    r.typed = 1'b0;
    r.want = '{hit_index: '0, hit: 1'b0, last: 1'b0};
    r.reg_idx = srsh_pkg::REG_RECEIVER_COUNT;
    r.value = '0;
    return r;
  endfunction

  function automatic row_t mk_write(int i, coord_t x, coord_t y, coord_t z);
    row_t r;
    r = blank_row(ROW_TXN);
    r.t = '{op: srsh_pkg::OP_WRITE, idx: i[3:0], rx: x, ry: y, rz: z, default: '0};
    return r;
  endfunction

  function automatic row_t mk_query(coord_t sx, coord_t sy, coord_t sz, coord_t ex,
                                    coord_t ey, coord_t ez, bit typed, hit_rec_t want);
    row_t r;
    r = blank_row(ROW_TXN);
    r.t = '{op: srsh_pkg::OP_QUERY, idx: 4'hF, rx: '1, ry: '1, rz: '1, sx: sx, sy: sy,
            sz: sz, ex: ex, ey: ey, ez: ez};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t mk_cfg(srsh_pkg::cfg_reg_t idx, logic [30:0] value);
    row_t r;
    r = blank_row(ROW_CFG);
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  initial begin
    hit_rec_t none, first0;
    logic [30:0] rad;
    none = '{hit_index: '0, hit: 1'b0, last: 1'b1};
    first0 = '{hit_index: '0, hit: 1'b1, last: 1'b1};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.operation = srsh_pkg::OP_WRITE;
    in_chan.entry_index = '0;
    {in_chan.receiver_x, in_chan.receiver_y, in_chan.receiver_z} = '0;
    {in_chan.start_x, in_chan.start_y, in_chan.start_z} = '0;
    {in_chan.end_x, in_chan.end_y, in_chan.end_z} = '0;
    out_chan.ready = 1'b0;
    for (int i = 0; i < 16; i++) begin tab_x[i] = 0; tab_y[i] = 0; tab_z[i] = 0; end
    rcv_count = 0;
    radius = 0;

    // count 0 after reset: no hit
    rows = {rows, mk_query(32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF,
                           0, 1, none)};
    rows = {rows, mk_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000, 32'sh80000000, 1, none)};
    rows = {rows, mk_write(0, 0, 0, 0)};
    rows = {rows, mk_write(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF)};
    rows = {rows, mk_write(2, 32'sh80000000, 32'sh80000000, 32'sh80000000)};
    for (int i = 3; i < 16; i++) rows = {rows, mk_write(i, i << 16, -(i << 16), 0)};
    rows = {rows, mk_cfg(srsh_pkg::REG_RECEIVER_COUNT, 31'd16)};
    rows = {rows, mk_cfg(srsh_pkg::REG_SPHERE_RADIUS, 31'h7FFFFFFF)};
    rows = {rows, mk_query(1 << 16, 1 << 16, 1 << 16, 2 << 16, 2 << 16, 2 << 16, 1, first0)};
    rows = {rows, mk_query(0, 0, 0, 0, 0, 0, 0, none)};          // most receivers hit
    rows = {rows, mk_cfg(srsh_pkg::REG_SPHERE_RADIUS, 31'd0)};
    rows = {rows, mk_query(3 << 16, -(3 << 16), 0, 3 << 16, -(3 << 16), 0, 0, none)};
    rows = {rows, mk_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                           32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, none)};
    rows = {rows, mk_cfg(srsh_pkg::REG_RECEIVER_COUNT, 31'd31)};  // saturates to 16
    rows = {rows, mk_cfg(srsh_pkg::REG_SPHERE_RADIUS, 31'(1 << 16))};
    rows = {rows, mk_query(5 << 16, -(5 << 16), -(1 << 16), 5 << 16, -(5 << 16), 1 << 16,
                           0, none)};
    rows = {rows, mk_query(9 << 16, -(9 << 16), 3 << 16, 9 << 16, -(9 << 16), 1 << 17,
                           0, none)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        send_txn(rows[i].t, rows[i].typed, rows[i].want);
      end
    end

    // random phases over several count and radius settings
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: rad = 31'h7FFFFFFF;
        1: rad = 0;
        default: rad = 31'(1) << $urandom_range(12, 24);
      endcase
      write_reg(srsh_pkg::REG_SPHERE_RADIUS, rad);
      write_reg(srsh_pkg::REG_RECEIVER_COUNT,
                31'((p == 2) ? 0 : (p == 3) ? $urandom_range(17, 31) : $urandom_range(1, 16)));
      repeat (18) send_txn(rand_txn(), 0, none);
    end

    wait_idle();
    $display("covered %0d queries, %0d result transactions, %0d of them hits",
             n_queries, n_results, n_hits);
    if (errors == 0) $display("segment_receiver_sphere_hits_core verification clean");
    else $display("segment_receiver_sphere_hits_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/srsh_pkg.sv
hdl/srsh_if.sv
hdl/srsh_datapath.sv
hdl/srsh_ctrl.sv
hdl/segment_receiver_sphere_hits_core.sv
hdl/srsh_checker.sv
tb/sv/segment_receiver_sphere_hits_core_tb.sv
